[rtl/fixed_partition_fit_allocator_assert.svh]
// Assertion macros shared by the allocator RTL.
// Each check samples on the rising edge of clk and is off while rst_n is low.
`ifndef FIXED_PARTITION_FIT_ALLOCATOR_ASSERT_SVH
`define FIXED_PARTITION_FIT_ALLOCATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define FPFA_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("allocator check failed");
`define FPFA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("allocator check failed");
`else
`define FPFA_ASSERT_SAME(label, ante, cons)
`define FPFA_ASSERT_NEXT(label, ante, cons)
`endif
`endif

[rtl/fpfa_pkg.sv]
package fpfa_pkg;

    // Table geometry.
    localparam int MAX_BLOCKS = 16;
    localparam int SIZE_BITS  = 16;
    localparam int IDX_W      = $clog2(MAX_BLOCKS);
    localparam int CNT_W      = IDX_W + 1;

    // Fixed field widths of the command and register interface.
    localparam int ACTION_W = 2;
    localparam int LOAD_W   = 4;
    localparam int STATUS_W = 2;
    localparam int GRANT_W  = 4;
    localparam int POLICY_W = 2;
    localparam int BIU_W    = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_POLICY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCKS = 2'd1;

    typedef enum logic [ACTION_W-1:0] {
        ACT_LOAD    = 2'd0,
        ACT_REQUEST = 2'd1,
        ACT_CLEAR   = 2'd2
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE    = 2'd0,
        ST_ALLOC   = 2'd1,
        ST_NOALLOC = 2'd2
    } status_t;

    typedef enum logic [POLICY_W-1:0] {
        POL_FIRST = 2'd0,
        POL_NEXT  = 2'd1,
        POL_BEST  = 2'd2,
        POL_WORST = 2'd3
    } policy_t;

    typedef struct packed {
        logic [ACTION_W-1:0]  action;
        logic [LOAD_W-1:0]    load_index;
        logic [SIZE_BITS-1:0] size_value;
    } in_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [GRANT_W-1:0]  granted_block;
    } out_item_t;

    // Control from the sequencer to the fit unit.
    typedef struct packed {
        logic    clear;
        logic    eval;
        policy_t policy;
    } fit_ctrl_t;

    // Report from the fit unit to the sequencer.
    typedef struct packed {
        logic             hit;
        logic             found;
        logic [IDX_W-1:0] best_idx;
    } fit_stat_t;

endpackage

[rtl/fpfa_fit_unit.sv]
module fpfa_fit_unit
    import fpfa_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  fit_ctrl_t            ctrl,
    input  logic [SIZE_BITS-1:0] want,
    input  logic [IDX_W-1:0]     cand_idx,
    input  logic [SIZE_BITS-1:0] cand_size,
    input  logic                 cand_free,
    output fit_stat_t            stat
);

    logic                 found_reg;
    logic                 found_next;
    logic [IDX_W-1:0]     best_idx_reg;
    logic [IDX_W-1:0]     best_idx_next;
    logic [SIZE_BITS-1:0] best_size_reg;
    logic [SIZE_BITS-1:0] best_size_next;
    logic                 fits;
    logic                 better;

    // One candidate per cycle while eval is high: does it fit, and does it beat the kept one.
    always_comb
    begin
        fits   = cand_free && (cand_size >= want);
        better = !found_reg
              || ((ctrl.policy == POL_BEST)  && (cand_size < best_size_reg))
              || ((ctrl.policy == POL_WORST) && (cand_size > best_size_reg));

        found_next     = found_reg;
        best_idx_next  = best_idx_reg;
        best_size_next = best_size_reg;
        if (ctrl.clear)
        begin
            found_next = 1'b0;
        end
        else if (ctrl.eval && fits && better)
        begin
            found_next     = 1'b1;
            best_idx_next  = cand_idx;
            best_size_next = cand_size;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else
        begin
            found_reg <= found_next;
        end
    end

    // The kept size and index are payload and qualified by the found flag.
    always_ff @(posedge clk)
    begin
        best_idx_reg  <= best_idx_next;
        best_size_reg <= best_size_next;
    end

    assign stat.hit      = ctrl.eval && fits;
    assign stat.found    = found_reg;
    assign stat.best_idx = best_idx_reg;

`include "fixed_partition_fit_allocator_assert.svh"

    `FPFA_ASSERT_NEXT(a_clear_drops_found, ctrl.clear, !found_reg)
    `FPFA_ASSERT_NEXT(a_fit_sets_found, (!ctrl.clear && ctrl.eval && fits), found_reg)
    `FPFA_ASSERT_SAME(a_hit_is_eval, stat.hit, ctrl.eval && cand_free)

endmodule

[rtl/fixed_partition_fit_allocator.sv]
// Channel   | Ports                              | Transfer
// ----------+------------------------------------+---------------------------------
// command   | start, busy, item                  | edge with start high, busy low
// result    | done, result                       | edge that ends the done cycle
// registers | cfg_we, cfg_index, cfg_data        | edge with cfg_we high
//
// Load, clear and unused commands, and requests with no active block, give their
// result in the cycle right after the transfer, with busy staying low.
// A request walks the n active blocks (blocks_in_use saturated at 16) through one
// table read port and one fit compare unit, one block a cycle: busy stays high through
// the scan and the finish state, and the result follows in the next cycle; the scan ends
// early when first or next fit finds a block.
// rst_n clears marks, next-fit start and registers; block sizes are not cleared.
// The receiver cannot stall; each result is shown for exactly one cycle.
module fixed_partition_fit_allocator
    import fpfa_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  in_item_t              item,
    output logic                  done,
    output out_item_t             result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } state_t;

    state_t               state_reg;
    policy_t              policy_reg;
    logic [BIU_W-1:0]     biu_reg;
    logic [MAX_BLOCKS-1:0] marks_reg;
    logic [IDX_W-1:0]     nfs_reg;
    logic [SIZE_BITS-1:0] want_reg;
    logic [IDX_W-1:0]     addr_reg;
    logic [CNT_W-1:0]     k_reg;
    logic                 cand_valid_reg;
    logic                 cand_last_reg;
    logic [IDX_W-1:0]     cand_idx_reg;
    logic                 done_reg;
    out_item_t            result_reg;

    logic [SIZE_BITS-1:0] size_mem [MAX_BLOCKS];
    logic [SIZE_BITS-1:0] rd_data_reg;

    logic [CNT_W-1:0]     n_active;
    logic [IDX_W-1:0]     scan_first;
    logic [IDX_W-1:0]     addr_step;
    logic                 accept;
    logic                 mem_we;
    logic                 issue;
    logic                 stop_early;
    logic [IDX_W-1:0]     nfs_after;
    fit_ctrl_t            fit_ctrl;
    fit_stat_t            fit_stat;

    // Register writes; indexes beyond the list are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= POL_FIRST;
            biu_reg    <= BIU_W'(MAX_BLOCKS);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_POLICY: policy_reg <= policy_t'(cfg_data[POLICY_W-1:0]);
                REG_BLOCKS: biu_reg    <= cfg_data[BIU_W-1:0];
                default:    ;
            endcase
        end
    end

    // Active block count saturates at the table depth.
    assign n_active = (CNT_W'(biu_reg) > CNT_W'(MAX_BLOCKS))
                    ? CNT_W'(MAX_BLOCKS) : CNT_W'(biu_reg);
    assign scan_first = (CNT_W'(nfs_reg) < n_active) ? nfs_reg : '0;
    assign addr_step  = ((CNT_W'(addr_reg) + CNT_W'(1)) >= n_active)
                      ? '0 : addr_reg + IDX_W'(1);
    assign nfs_after  = ((CNT_W'(fit_stat.best_idx) + CNT_W'(1)) >= n_active)
                      ? '0 : fit_stat.best_idx + IDX_W'(1);

    assign accept = start && (state_reg == S_IDLE);
    assign mem_we = accept && (item.action == ACT_LOAD)
                 && (CNT_W'(item.load_index) < CNT_W'(MAX_BLOCKS));
    assign issue  = (state_reg == S_SCAN) && (k_reg < n_active);

    // Size table: one write port for loads, one registered read port for scans.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            size_mem[item.load_index[IDX_W-1:0]] <= item.size_value;
        end
        if (issue)
        begin
            rd_data_reg <= size_mem[addr_reg];
        end
    end

    // The fit unit judges the candidate whose size has just been read.
    always_comb
    begin
        fit_ctrl.clear  = accept;
        fit_ctrl.eval   = (state_reg == S_SCAN) && cand_valid_reg;
        fit_ctrl.policy = policy_reg;
    end

    fpfa_fit_unit u_fit
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (fit_ctrl),
        .want      (want_reg),
        .cand_idx  (cand_idx_reg),
        .cand_size (rd_data_reg),
        .cand_free (!marks_reg[cand_idx_reg]),
        .stat      (fit_stat)
    );

    assign stop_early = fit_stat.hit
                     && ((policy_reg == POL_FIRST) || (policy_reg == POL_NEXT));

    // Sequencer: command decode, scan control, marks and registered result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            marks_reg      <= '0;
            nfs_reg        <= '0;
            cand_valid_reg <= 1'b0;
            cand_last_reg  <= 1'b0;
            done_reg       <= 1'b0;
            result_reg     <= '0;
            want_reg       <= '0;
            addr_reg       <= '0;
            k_reg          <= '0;
            cand_idx_reg   <= '0;
        end
        else
        begin
            // A result leaves after a finished scan or right after any other command.
            done_reg       <= (state_reg == S_FINISH)
                           || (accept && ((item.action != ACT_REQUEST) || (n_active == '0)));
            cand_valid_reg <= issue;
            if (issue)
            begin
                cand_idx_reg  <= addr_reg;
                cand_last_reg <= (k_reg == (n_active - CNT_W'(1)));
                addr_reg      <= addr_step;
                k_reg         <= k_reg + CNT_W'(1);
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        case (item.action)
                            ACT_REQUEST:
                            begin
                                if (n_active == '0)
                                begin
                                    result_reg <= {ST_NOALLOC, GRANT_W'(0)};
                                end
                                else
                                begin
                                    result_reg <= '0;
                                    want_reg  <= item.size_value;
                                    addr_reg  <= (policy_reg == POL_NEXT) ? scan_first : '0;
                                    k_reg     <= '0;
                                    state_reg <= S_SCAN;
                                end
                            end
                            ACT_CLEAR:
                            begin
                                result_reg <= '0;
                                marks_reg  <= '0;
                                nfs_reg    <= '0;
                            end
                            default:
                            begin
                                result_reg <= '0;
                            end
                        endcase
                    end
                end
                S_SCAN:
                begin
                    if (fit_ctrl.eval && (stop_early || cand_last_reg))
                    begin
                        state_reg <= S_FINISH;
                    end
                end
                S_FINISH:
                begin
                    state_reg <= S_IDLE;
                    if (fit_stat.found)
                    begin
                        marks_reg[fit_stat.best_idx] <= 1'b1;
                        result_reg <= {ST_ALLOC, GRANT_W'(fit_stat.best_idx)};
                        if (policy_reg == POL_NEXT)
                        begin
                            nfs_reg <= nfs_after;
                        end
                    end
                    else
                    begin
                        result_reg <= {ST_NOALLOC, GRANT_W'(0)};
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

`include "fixed_partition_fit_allocator_assert.svh"

    `FPFA_ASSERT_SAME(a_grant_marked, (done_reg && (result_reg.status == ST_ALLOC)), marks_reg[result_reg.granted_block[IDX_W-1:0]])
    `FPFA_ASSERT_NEXT(a_accept_answers, accept, (done_reg || busy))
    `FPFA_ASSERT_SAME(a_scan_bounded, (state_reg == S_SCAN), (k_reg <= n_active))
    `FPFA_ASSERT_SAME(a_no_done_busy, done_reg, (state_reg == S_IDLE))

endmodule

[test/testbench.sv]
module testbench;
    import fpfa_pkg::*;

    // Codes the package leaves unnamed: the spare command and the spare register slots.
    localparam logic [ACTION_W-1:0]  ACT_SPARE   = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
    localparam int SETTLE_CYCLES = MAX_BLOCKS + 8;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    in_item_t item = '0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic busy;
    logic done;
    out_item_t result;

    // Commands waiting for the driver, and the outcomes still owed by the block.
    in_item_t pending_commands[$];
    out_item_t owed_outcomes[$];

    // Allocator state as the testbench expects it.
    logic [SIZE_BITS-1:0] block_sizes [MAX_BLOCKS];
    bit [MAX_BLOCKS-1:0] alloc_marks = '0;
    logic [IDX_W-1:0] scan_start = '0;
    policy_t fit_policy = POL_FIRST;
    logic [BIU_W-1:0] active_blocks = 5'd16;

    int burst_left = 1;
    int gap_left = 0;
    int mismatch_count = 0;
    int transfer_count = 0;
    int granted_count = 0;
    int refused_count = 0;
    int setting_count = 0;

    fixed_partition_fit_allocator uut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .item(item),
        .done(done),
        .result(result),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    function automatic bit block_free_for(int b, logic [SIZE_BITS-1:0] want);
        return !alloc_marks[b] && block_sizes[b] >= want;
    endfunction

    // Apply one command to the expected state and return the outcome it must produce.
    function automatic out_item_t predict_grant(in_item_t cmd);
        out_item_t res;
        int count;
        int pick;
        int j;
        res = '0;
        pick = -1;
        count = (active_blocks > MAX_BLOCKS) ? MAX_BLOCKS : int'(active_blocks);
        case (cmd.action)
            ACT_LOAD:
                block_sizes[cmd.load_index] = cmd.size_value;
            ACT_CLEAR:
            begin
                alloc_marks = '0;
                scan_start = '0;
            end
            ACT_REQUEST:
            begin
                if (fit_policy == POL_NEXT) begin
                    j = (scan_start < count) ? int'(scan_start) : 0;
                    for (int k = 0; k < count && pick < 0; k++) begin
                        if (block_free_for(j, cmd.size_value))
                            pick = j;
                        else
                            j = (j + 1 >= count) ? 0 : j + 1;
                    end
                    if (pick >= 0)
                        scan_start = (pick + 1 >= count) ? '0 : IDX_W'(pick + 1);
                end else begin
                    // First fit keeps the lowest hit; best and worst replace only on a strict win.
                    for (int b = 0; b < count; b++) begin
                        if (block_free_for(b, cmd.size_value) &&
                            (pick < 0 ||
                             (fit_policy == POL_BEST && block_sizes[b] < block_sizes[pick]) ||
                             (fit_policy == POL_WORST && block_sizes[b] > block_sizes[pick])))
                            pick = b;
                    end
                end
                if (pick >= 0) begin
                    alloc_marks[pick] = 1'b1;
                    res.status = ST_ALLOC;
                    res.granted_block = GRANT_W'(pick);
                end else begin
                    res.status = ST_NOALLOC;
                end
            end
            default:
                ;
        endcase
        return res;
    endfunction

    function automatic void note_mismatch(string what, int want, int got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("Mismatch at %0t: %s expected %0d, got %0d", $time, what, want, got);
    endfunction

    function automatic void queue_command(logic [ACTION_W-1:0] act, int idx, int size);
        in_item_t cmd;
        cmd.action = act;
        cmd.load_index = LOAD_W'(idx);
        cmd.size_value = SIZE_BITS'(size);
        pending_commands.push_back(cmd);
    endfunction

    // Random command with sizes drawn around the current table so that hits and misses mix.
    function automatic in_item_t random_command();
        in_item_t cmd;
        int pick;
        int base;
        pick = $urandom_range(0, 99);
        cmd.load_index = LOAD_W'($urandom_range(0, MAX_BLOCKS - 1));
        cmd.size_value = SIZE_BITS'($urandom);
        if (pick < 50) begin
            cmd.action = ACT_REQUEST;
            base = int'(block_sizes[$urandom_range(0, MAX_BLOCKS - 1)]);
            case ($urandom_range(0, 5))
                0, 1, 2: cmd.size_value = SIZE_BITS'(base + $urandom_range(0, 2) - 1);
                3: cmd.size_value = SIZE_BITS'($urandom_range(0, 40));
                4: cmd.size_value = $urandom_range(0, 1) ? '0 : '1;
                default: ;
            endcase
        end else if (pick < 80) begin
            cmd.action = ACT_LOAD;
            case ($urandom_range(0, 4))
                0, 1: cmd.size_value = SIZE_BITS'($urandom_range(0, 15));
                2: cmd.size_value = SIZE_BITS'($urandom_range(0, 1023));
                3: cmd.size_value = $urandom_range(0, 1) ? '0 : '1;
                default: ;
            endcase
        end else if (pick < 92) begin
            cmd.action = ACT_CLEAR;
        end else begin
            cmd.action = ACT_SPARE;
        end
        return cmd;
    endfunction

    // One register write; the expected settings follow at the same edge.
    task automatic set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_POLICY)
            fit_policy = policy_t'(val[POLICY_W-1:0]);
        else if (idx == REG_BLOCKS)
            active_blocks = val;
    endtask

    // Wait until every queued command has transferred and every outcome has come back.
    task automatic wait_idle();
        do
            @(posedge clk);
        while (pending_commands.size() != 0 || start || owed_outcomes.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_setting(policy_t pol, logic [BIU_W-1:0] blocks, int count);
        logic [CFG_DATA_W-POLICY_W-1:0] junk;
        junk = (CFG_DATA_W-POLICY_W)'($urandom_range(0, 7));
        set_register(REG_POLICY, {junk, pol});
        set_register(REG_BLOCKS, blocks);
        set_register($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
                     CFG_DATA_W'($urandom_range(0, 31)));
        setting_count++;
        for (int i = 0; i < count; i++)
            pending_commands.push_back(random_command());
        wait_idle();
    endtask

    // Command driver: bursts of transfers separated by random gaps.
    always @(posedge clk) begin : drive_commands
        if (rst_n && !(start && busy)) begin
            if (start) begin
                burst_left = burst_left - 1;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 12);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
            if (gap_left > 0) begin
                gap_left = gap_left - 1;
                start <= 1'b0;
            end else if (pending_commands.size() != 0) begin
                start <= 1'b1;
                item <= pending_commands.pop_front();
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Result monitor: check each strobed result, then record the command taken at this edge.
    always @(posedge clk) begin : watch_results
        out_item_t want;
        if (rst_n) begin
            if (done) begin
                if (owed_outcomes.size() == 0) begin
                    note_mismatch("unexpected result, status", -1, int'(result.status));
                end else begin
                    want = owed_outcomes.pop_front();
                    if (result.status !== want.status)
                        note_mismatch("status", int'(want.status), int'(result.status));
                    if (result.granted_block !== want.granted_block)
                        note_mismatch("granted block", int'(want.granted_block),
                                      int'(result.granted_block));
                    if (want.status == ST_ALLOC)
                        granted_count++;
                    else if (want.status == ST_NOALLOC)
                        refused_count++;
                end
            end
            if (start && !busy) begin
                owed_outcomes.push_back(predict_grant(item));
                transfer_count++;
            end
        end
    end

    initial begin
        #2_000_000;
        $display("Run timed out with %0d results outstanding.", owed_outcomes.size());
        $display("FAIL fixed_partition_fit_allocator");
        $finish;
    end

    initial begin : stimulus
        int directed_sizes [MAX_BLOCKS];
        directed_sizes = '{100, 40, 65535, 0, 40, 300, 100, 7,
                           65535, 1, 500, 40, 2, 1000, 3, 32768};
        for (int b = 0; b < MAX_BLOCKS; b++)
            block_sizes[b] = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part under reset settings: fill the whole table, then hit the edges.
        for (int b = 0; b < MAX_BLOCKS; b++)
            queue_command(ACT_LOAD, b, directed_sizes[b]);
        queue_command(ACT_REQUEST, 0, 0);
        queue_command(ACT_REQUEST, 15, 65535);
        queue_command(ACT_REQUEST, 3, 65535);
        queue_command(ACT_REQUEST, 9, 65535);
        queue_command(ACT_SPARE, 15, 65535);
        queue_command(ACT_CLEAR, 0, 0);
        queue_command(ACT_REQUEST, 0, 40);
        wait_idle();

        run_setting(POL_NEXT, 5'd16, 160);
        // Push the next-fit start past block 7 so a smaller block count must restart at zero.
        queue_command(ACT_CLEAR, 0, 0);
        for (int i = 0; i < 8; i++)
            queue_command(ACT_REQUEST, i, 0);
        wait_idle();
        run_setting(POL_NEXT, 5'd5, 120);
        run_setting(POL_BEST, 5'd16, 160);
        run_setting(POL_WORST, 5'd16, 160);
        run_setting(POL_FIRST, 5'd1, 60);
        run_setting(POL_BEST, 5'd0, 40);
        run_setting(POL_WORST, 5'd31, 120);
        run_setting(POL_NEXT, 5'd20, 120);
        run_setting(POL_FIRST, 5'd16, 110);

        $display("Checked %0d commands over %0d register settings plus reset defaults.",
                 transfer_count, setting_count);
        $display("Requests granted %0d, refused %0d, under all four fit policies; %0d mismatches.",
                 granted_count, refused_count, mismatch_count);
        if (mismatch_count == 0)
            $display("PASS fixed_partition_fit_allocator");
        else
            $display("FAIL fixed_partition_fit_allocator");
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl
rtl/fpfa_pkg.sv
rtl/fpfa_fit_unit.sv
rtl/fixed_partition_fit_allocator.sv
test/testbench.sv
